/* hw/rtl/arc_pkg.sv */
// shared types and codes for the audio record control state machine
package arc_pkg;

  typedef enum logic [2:0] {
    ST_UNINIT   = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_BUFFER   = 3'd2,
    ST_WAITTRIG = 3'd3,
    ST_PREREC   = 3'd4,
    ST_RECORD   = 3'd5,
    ST_PAUSED   = 3'd6,
    ST_DONE     = 3'd7
  } state_t;

  typedef enum logic [3:0] {
    CMD_INIT        = 4'd0,
    CMD_DEINIT      = 4'd1,
    CMD_RESET       = 4'd2,
    CMD_STOP        = 4'd3,
    CMD_PAUSE       = 4'd4,
    CMD_START       = 4'd5,
    CMD_REC_STARTED = 4'd6,
    CMD_BUF_FULL    = 4'd7,
    CMD_TRIGGER     = 4'd8,
    CMD_REC_STOPPED = 4'd9
  } cmd_t;

  // configuration register indexes
  localparam logic REG_TRIGGER_ENABLE   = 1'b0;
  localparam logic REG_PRERECORD_ENABLE = 1'b1;

  typedef struct packed {
    logic unexpected_event;
    logic reset_request;
    logic stop_request;
    logic start_request;
    logic state_changed;
  } flags_t;

endpackage

/* hw/rtl/audio_record_control_fsm_top.sv */
// Audio record control state machine: one event in, one state/flag result out.
// Takes one event request per clock. Each accepted event yields exactly one result in the
// next cycle, from a single output register fed by the state lookup on the current and pending
// state. in_tready drops only while a result sits in that register unread and out_tready is
// low. Configuration (trigger enable at byte 0, prerecord enable at byte 4) must be written over
// the APB-style port only while no event is in flight; the block itself does not enforce this.
module audio_record_control_fsm_top (
  input  logic        clk,
  input  logic        rst_n,
  // input events
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // command[3:0], signal_empty[4], reset_accepted[5], zero[7:6]
  // results
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // record_state[2:0], state_changed[3], start_request[4],
                                  // stop_request[5], reset_request[6], unexpected_event[7]
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  arc_pkg::state_t cur_r, cur_nxt;
  arc_pkg::state_t pend_r, pend_nxt;
  arc_pkg::state_t idle_st;
  arc_pkg::cmd_t   cmd;
  arc_pkg::flags_t flags;
  logic            sig_empty, rst_acc;
  logic            trig_en_r, prerec_en_r;
  logic            out_valid_r;
  logic [7:0]      out_data_r, out_data_nxt;
  logic            in_acc, cfg_wr;

  assign cmd       = arc_pkg::cmd_t'(in_tdata[3:0]);
  assign sig_empty = in_tdata[4];
  assign rst_acc   = in_tdata[5];
  assign idle_st   = sig_empty ? arc_pkg::ST_EMPTY : arc_pkg::ST_DONE;

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_en_r   <= 1'b0;
      prerec_en_r <= 1'b0;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == arc_pkg::REG_TRIGGER_ENABLE) begin
        trig_en_r <= cfg_pwdata[0];
      end else begin
        prerec_en_r <= cfg_pwdata[0];
      end
    end
  end

  always_comb begin
    if (cfg_paddr[2] == arc_pkg::REG_PRERECORD_ENABLE) begin
      cfg_prdata = {31'd0, prerec_en_r};
    end else begin
      cfg_prdata = {31'd0, trig_en_r};
    end
  end

  // next state and pending state
  always_comb begin
    cur_nxt  = cur_r;
    pend_nxt = pend_r;
    case (cmd)
      arc_pkg::CMD_INIT: begin
        pend_nxt = idle_st;
        cur_nxt  = arc_pkg::ST_EMPTY;
      end
      arc_pkg::CMD_DEINIT: begin
        pend_nxt = arc_pkg::ST_UNINIT;
        cur_nxt  = arc_pkg::ST_UNINIT;
      end
      arc_pkg::CMD_RESET: begin
        if (cur_r != arc_pkg::ST_UNINIT && rst_acc) cur_nxt = arc_pkg::ST_EMPTY;
      end
      arc_pkg::CMD_STOP: begin
        if (cur_r inside {arc_pkg::ST_RECORD, arc_pkg::ST_PAUSED}) pend_nxt = arc_pkg::ST_DONE;
      end
      arc_pkg::CMD_PAUSE: begin
        if (cur_r == arc_pkg::ST_RECORD) cur_nxt = arc_pkg::ST_PAUSED;
        else if (cur_r == arc_pkg::ST_PAUSED) cur_nxt = arc_pkg::ST_RECORD;
      end
      arc_pkg::CMD_START: begin
        if (cur_r inside {arc_pkg::ST_BUFFER, arc_pkg::ST_PREREC, arc_pkg::ST_WAITTRIG}) begin
          pend_nxt = arc_pkg::ST_EMPTY;
          cur_nxt  = arc_pkg::ST_RECORD;
        end else if (cur_r == arc_pkg::ST_PAUSED) begin
          pend_nxt = arc_pkg::ST_RECORD;
          cur_nxt  = arc_pkg::ST_RECORD;
        end else if (cur_r == arc_pkg::ST_RECORD) begin
          pend_nxt = arc_pkg::ST_DONE;
        end
      end
      arc_pkg::CMD_REC_STARTED: begin
        if (cur_r inside {arc_pkg::ST_EMPTY, arc_pkg::ST_PAUSED, arc_pkg::ST_DONE}) begin
          pend_nxt = idle_st;
          cur_nxt  = arc_pkg::ST_BUFFER;
        end
      end
      arc_pkg::CMD_BUF_FULL: begin
        if (cur_r == arc_pkg::ST_BUFFER) begin
          if (prerec_en_r) cur_nxt = arc_pkg::ST_PREREC;
          else if (trig_en_r) cur_nxt = arc_pkg::ST_WAITTRIG;
          else begin
            pend_nxt = arc_pkg::ST_DONE;
            cur_nxt  = arc_pkg::ST_RECORD;
          end
        end
      end
      arc_pkg::CMD_TRIGGER: begin
        if (cur_r == arc_pkg::ST_WAITTRIG && prerec_en_r) begin
          cur_nxt = arc_pkg::ST_PREREC;
        end else if (cur_r inside {arc_pkg::ST_PREREC, arc_pkg::ST_WAITTRIG}) begin
          cur_nxt  = arc_pkg::ST_RECORD;
          pend_nxt = arc_pkg::ST_DONE;
        end
      end
      arc_pkg::CMD_REC_STOPPED: begin
        if (cur_r inside {arc_pkg::ST_BUFFER, arc_pkg::ST_PREREC, arc_pkg::ST_WAITTRIG}) begin
          cur_nxt = idle_st;
        end else if (cur_r == arc_pkg::ST_RECORD) begin
          if (pend_r == arc_pkg::ST_EMPTY) cur_nxt = idle_st;
          else if (pend_r == arc_pkg::ST_PAUSED) cur_nxt = arc_pkg::ST_PAUSED;
          else if (pend_r == arc_pkg::ST_DONE) cur_nxt = arc_pkg::ST_DONE;
        end else if (cur_r == arc_pkg::ST_PAUSED) begin
          cur_nxt = arc_pkg::ST_DONE;
        end
      end
      default: begin
        cur_nxt  = cur_r;
        pend_nxt = pend_r;
      end
    endcase
  end

  // result flags
  always_comb begin
    flags = '0;
    case (cmd)
      arc_pkg::CMD_INIT, arc_pkg::CMD_DEINIT: flags.state_changed = 1'b1;
      arc_pkg::CMD_RESET: begin
        if (cur_r != arc_pkg::ST_UNINIT) begin
          flags.reset_request = 1'b1;
          flags.state_changed = rst_acc;
        end
      end
      arc_pkg::CMD_STOP: begin
        flags.stop_request = (cur_r inside {arc_pkg::ST_BUFFER, arc_pkg::ST_WAITTRIG,
                              arc_pkg::ST_PREREC, arc_pkg::ST_RECORD, arc_pkg::ST_PAUSED});
      end
      arc_pkg::CMD_PAUSE: begin
        flags.unexpected_event = (cur_r inside {arc_pkg::ST_BUFFER, arc_pkg::ST_WAITTRIG,
                                  arc_pkg::ST_PREREC});
        flags.state_changed    = (cur_r inside {arc_pkg::ST_RECORD, arc_pkg::ST_PAUSED});
      end
      arc_pkg::CMD_START: begin
        flags.unexpected_event = (cur_r == arc_pkg::ST_UNINIT);
        flags.start_request    = (cur_r inside {arc_pkg::ST_EMPTY, arc_pkg::ST_DONE});
        flags.state_changed    = (cur_r inside {arc_pkg::ST_BUFFER, arc_pkg::ST_PREREC,
                                  arc_pkg::ST_WAITTRIG, arc_pkg::ST_PAUSED});
      end
      arc_pkg::CMD_REC_STARTED: begin
        flags.state_changed    = (cur_r inside {arc_pkg::ST_EMPTY, arc_pkg::ST_PAUSED,
                                  arc_pkg::ST_DONE});
        flags.unexpected_event = !flags.state_changed;
      end
      arc_pkg::CMD_BUF_FULL: begin
        flags.unexpected_event = (cur_r inside {arc_pkg::ST_UNINIT, arc_pkg::ST_WAITTRIG,
                                  arc_pkg::ST_PREREC, arc_pkg::ST_RECORD});
        flags.state_changed    = (cur_r == arc_pkg::ST_BUFFER);
      end
      arc_pkg::CMD_TRIGGER: begin
        flags.state_changed    = (cur_r inside {arc_pkg::ST_PREREC, arc_pkg::ST_WAITTRIG});
        flags.unexpected_event = !flags.state_changed;
      end
      arc_pkg::CMD_REC_STOPPED: begin
        // recording with an odd pending state keeps its state
        if (cur_r == arc_pkg::ST_RECORD &&
            !(pend_r inside {arc_pkg::ST_EMPTY, arc_pkg::ST_PAUSED, arc_pkg::ST_DONE})) begin
          flags.unexpected_event = 1'b1;
        end else begin
          flags.state_changed = 1'b1;
        end
      end
      default: flags.unexpected_event = 1'b1;
    endcase
  end

  assign out_data_nxt = {flags.unexpected_event, flags.reset_request, flags.stop_request,
                         flags.start_request, flags.state_changed, cur_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r       <= arc_pkg::ST_UNINIT;
      pend_r      <= arc_pkg::ST_EMPTY;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        cur_r  <= cur_nxt;
        pend_r <= pend_nxt;
      end
      if (in_acc) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

/* hw/rtl/arc_checker.sv */
// port-level checks for the audio record control state machine, bound to the top level
module arc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic [7:0] in_tdata,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);

  logic in_acc;
  assign in_acc = in_tvalid && in_tready;

  // a result not yet taken holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // an empty output register never blocks a request
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // deinit lands in uninit with only state_changed set
  a_deinit: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tdata[3:0] == arc_pkg::CMD_DEINIT |=>
      out_tvalid && out_tdata == {5'b00001, arc_pkg::ST_UNINIT})
    else $error("deinit result wrong");

  // init lands in empty with only state_changed set
  a_init: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tdata[3:0] == arc_pkg::CMD_INIT |=>
      out_tvalid && out_tdata == {5'b00001, arc_pkg::ST_EMPTY})
    else $error("init result wrong");

  // unused command codes raise only unexpected_event
  a_unused: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_tdata[3:0] == 4'd10 || in_tdata[3:0] == 4'd11 || in_tdata[3:0] == 4'd12 ||
               in_tdata[3:0] == 4'd13 || in_tdata[3:0] == 4'd14 || in_tdata[3:0] == 4'd15)
      |=> out_tvalid && out_tdata[7:3] == 5'b10000)
    else $error("unused command result wrong");

endmodule

bind audio_record_control_fsm_top arc_checker u_arc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
